@@ src/assert_macros.svh @@
// Assertion macros shared by the compass heading RTL.
// Each macro expects signals named clock and reset in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge out of reset
`define CHM_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// post must hold in the cycle after pre
`define CHM_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

@@ src/chm_pkg.sv @@
// Constants and types for the compass heading CORDIC pipeline.
// No dependencies; imported by compass_heading_from_magnetometer.
`default_nettype none

package chm_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int TABLE_LEN    = 24;
   localparam int NITER        = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

   localparam int AXIS_W  = 16;
   localparam int HEAD_W  = 15;
   localparam int FRAC    = 20;                  // x and y scaled by 2^20
   localparam int XY_W    = AXIS_W + FRAC + 4;   // room for pre-rotation and CORDIC gain
   localparam int ANG_W   = 33;                  // angle in 2^-22 degree, signed
   localparam int ANG_FRAC = 16;

   localparam int REQ_W = 48;   // raw_x, raw_y, raw_z
   localparam int RSP_W = 64;   // field_x, field_y, field_z, heading, pad

   localparam logic signed [ANG_W-1:0] DEG_90  = 33'sd377487360;
   localparam logic signed [ANG_W-1:0] DEG_180 = 33'sd754974720;
   localparam logic signed [ANG_W-1:0] DEG_360 = 33'sd1509949440;
   localparam logic signed [ANG_W-1:0] ROUND_HALF = 33'sd32768;

   localparam logic [HEAD_W-1:0] HEADING_FULL = 15'd23040;
   localparam logic [HEAD_W-1:0] OFFSET_RESET = 15'd6400;

   // atan(2^-i) in 2^-22 degree units, rounded to nearest
   localparam logic signed [ANG_W-1:0] ATAN_TAB [TABLE_LEN] = '{
      33'sd188743680, 33'sd111421900, 33'sd58872272, 33'sd29884485,
      33'sd15000234,  33'sd7507429,   33'sd3754631,  33'sd1877430,
      33'sd938729,    33'sd469366,    33'sd234683,   33'sd117342,
      33'sd58671,     33'sd29335,     33'sd14668,    33'sd7334,
      33'sd3667,      33'sd1833,      33'sd917,      33'sd458,
      33'sd229,       33'sd115,       33'sd57,       33'sd29
   };

   typedef struct packed {
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
      logic signed [ANG_W-1:0] z;
      logic [AXIS_W-1:0]       fx;
      logic [AXIS_W-1:0]       fy;
      logic [AXIS_W-1:0]       fz;
      logic                    zero;
   } cordic_type;

   typedef struct packed {
      logic [AXIS_W-1:0] fx;
      logic [AXIS_W-1:0] fy;
      logic [AXIS_W-1:0] fz;
      logic [HEAD_W-1:0] head;
   } head_type;

endpackage

`default_nettype wire

@@ src/compass_heading_from_magnetometer.sv @@
// Compass heading from one magnetometer sample: signed axis fields plus a CORDIC atan2 heading.
// Depends on chm_pkg and assert_macros.svh.
`default_nettype none

// Takes one beat of three raw axis words and returns one beat with the signed
// x, y, z fields and a heading in 1/64 degree (0..23040), offset by csr_wr_data
// (reset 6400, i.e. 100 degrees) and wrapped once at 23040. A zero x/y vector
// reads as atan2 = 0. A beat can enter every cycle unless every stage is full and
// rsp_tready is low. The stages are one entry stage with quadrant pre-rotation,
// one register stage per CORDIC iteration, one rounding stage and one offset
// stage. Every stage holds its own valid bit, so bubbles close up and input
// beats are taken while a result waits on rsp_tready as long as a stage is free.
module compass_heading_from_magnetometer (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [chm_pkg::REQ_W-1:0] req_tdata,   // raw_x, raw_y, raw_z
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [chm_pkg::RSP_W-1:0]      rsp_tdata,   // field_x, field_y, field_z, heading, 0
   input  wire logic                      csr_wr_en,
   input  wire logic [chm_pkg::HEAD_W-1:0] csr_wr_data  // heading_offset
);
   import chm_pkg::*;

   localparam int NST = NITER + 3;
   localparam int HS  = NITER + 1;   // rounding stage
   localparam int OS  = NITER + 2;   // output stage

   logic [NST-1:0]    valid_ff, valid_in;
   logic [NST-1:0]    ready;
   logic [HEAD_W-1:0] offset_ff;

   cordic_type        entry_in;
   cordic_type        pipe_ff [NITER+1];
   cordic_type        pipe_in [NITER+1];
   head_type          head_ff, head_in;
   logic [RSP_W-1:0]  rsp_tdata_ff, rsp_tdata_in;

   // stage k may load when it is empty or everything downstream moves
   always_comb begin
      for (int k = 0; k < NST; k++) begin
         ready[k] = rsp_tready || !(&(valid_ff | NST'((1 << k) - 1)));
      end
      valid_in[0] = ready[0] ? req_tvalid : valid_ff[0];
      for (int k = 1; k < NST; k++) begin
         if (ready[k]) begin
            valid_in[k] = valid_ff[k-1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   assign req_tready = ready[0];
   assign rsp_tvalid = valid_ff[OS];
   assign rsp_tdata  = rsp_tdata_ff;

   // entry: sign, scale and fold into the right half-plane
   always_comb begin
      logic signed [AXIS_W-1:0] fx, fy;
      logic signed [XY_W-1:0]   xs, ys;
      fx = signed'(req_tdata[AXIS_W-1:0]);
      fy = signed'(req_tdata[2*AXIS_W-1:AXIS_W]);
      xs = {{(XY_W-AXIS_W-FRAC){fx[AXIS_W-1]}}, fx, FRAC'(0)};
      ys = {{(XY_W-AXIS_W-FRAC){fy[AXIS_W-1]}}, fy, FRAC'(0)};
      entry_in.fx   = req_tdata[AXIS_W-1:0];
      entry_in.fy   = req_tdata[2*AXIS_W-1:AXIS_W];
      entry_in.fz   = req_tdata[3*AXIS_W-1:2*AXIS_W];
      entry_in.zero = (fx == '0) && (fy == '0);
      if (!xs[XY_W-1]) begin
         entry_in.x = xs;
         entry_in.y = ys;
         entry_in.z = '0;
      end else if (!ys[XY_W-1]) begin
         entry_in.x = ys;
         entry_in.y = -xs;
         entry_in.z = DEG_90;
      end else begin
         entry_in.x = -ys;
         entry_in.y = xs;
         entry_in.z = -DEG_90;
      end
   end

   // one vectoring iteration per stage; steer y towards zero
   always_comb begin
      pipe_in[0] = entry_in;
      for (int k = 0; k < NITER; k++) begin
         pipe_in[k+1] = pipe_ff[k];
         if (!pipe_ff[k].y[XY_W-1]) begin
            pipe_in[k+1].x = pipe_ff[k].x + (pipe_ff[k].y >>> k);
            pipe_in[k+1].y = pipe_ff[k].y - (pipe_ff[k].x >>> k);
            pipe_in[k+1].z = pipe_ff[k].z + ATAN_TAB[k];
         end else begin
            pipe_in[k+1].x = pipe_ff[k].x - (pipe_ff[k].y >>> k);
            pipe_in[k+1].y = pipe_ff[k].y + (pipe_ff[k].x >>> k);
            pipe_in[k+1].z = pipe_ff[k].z - ATAN_TAB[k];
         end
      end
   end

   // shift to 0..360 degrees, clamp, round half up to 1/64 degree
   always_comb begin
      logic signed [ANG_W-1:0] h, hr;
      h = (pipe_ff[NITER].zero ? ANG_W'(0) : pipe_ff[NITER].z) + DEG_180;
      if (h[ANG_W-1]) begin
         h = '0;
      end else if (h > DEG_360) begin
         h = DEG_360;
      end
      hr = h + ROUND_HALF;
      head_in.fx   = pipe_ff[NITER].fx;
      head_in.fy   = pipe_ff[NITER].fy;
      head_in.fz   = pipe_ff[NITER].fz;
      head_in.head = hr[ANG_FRAC +: HEAD_W];
      if (head_in.head > HEADING_FULL) begin
         head_in.head = HEADING_FULL;
      end
   end

   // add declination offset and wrap once
   always_comb begin
      logic [HEAD_W:0] sum;
      sum = {1'b0, head_ff.head} + {1'b0, offset_ff};
      if (sum > {1'b0, HEADING_FULL}) begin
         sum = sum - {1'b0, HEADING_FULL};
      end
      rsp_tdata_in = {1'b0, sum[HEAD_W-1:0], head_ff.fz, head_ff.fy, head_ff.fx};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         offset_ff <= OFFSET_RESET;
      end else begin
         valid_ff <= valid_in;
         if (csr_wr_en) begin
            offset_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= NITER; k++) begin
         if (ready[k]) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
      if (ready[HS]) begin
         head_ff <= head_in;
      end
      if (ready[OS]) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

`include "assert_macros.svh"

   `CHM_ASSERT(a_stall_only_when_full, req_tready || (&valid_ff && !rsp_tready), "stall with room")
   `CHM_ASSERT_NEXT(a_accept_enters, req_tvalid && req_tready, valid_ff[0], "beat lost")
   `CHM_ASSERT(a_x_folded, !valid_ff[0] || !pipe_ff[0].x[XY_W-1], "pre-rotation left x negative")

endmodule

`default_nettype wire
